// ----- rtl/status_led_blink_code_sequencer_macros.svh -----
// Assertion macros used by the blink code sequencer core.
`ifndef STATUS_LED_BLINK_CODE_SEQUENCER_MACROS_SVH
`define STATUS_LED_BLINK_CODE_SEQUENCER_MACROS_SVH

// Check a property on every rising clock edge outside of reset.
`define SLBCS_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define SLBCS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/slbcs_pkg.sv -----
// Types, codes and segment helpers of the status LED blink code sequencer.
`timescale 1ns / 1ps
`default_nettype none

package slbcs_pkg;

    // Sequence phases
    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_SRC  = 3'd1,
        PH_GAP1 = 3'd2,
        PH_CODE = 3'd3,
        PH_GAP2 = 3'd4
    } phase_t;

    // Item operation codes; the fourth code is ignored
    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_REQUEST = 2'd1,
        OP_OFF     = 2'd2
    } op_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_ACTIVE_LOW  = 2'd0,
        CFG_SC_GAP      = 2'd1,
        CFG_ROUND_GAP   = 2'd2,
        CFG_ROUND_TOTAL = 2'd3
    } cfg_idx_t;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 12;

    localparam logic [11:0] SC_GAP_RESET      = 12'd500;
    localparam logic [11:0] ROUND_GAP_RESET   = 12'd1500;
    localparam logic [3:0]  ROUND_TOTAL_RESET = 4'd2;

    typedef struct packed {
        logic        active_low;
        logic [11:0] sc_gap;
        logic [11:0] round_gap;
        logic [3:0]  round_total;
    } cfg_t;

    typedef struct packed {
        phase_t      phase;
        logic [11:0] timer;
        logic [3:0]  blink;
        logic        led;
        logic [3:0]  round;
        logic [3:0]  src;
        logic [3:0]  code;
        logic [9:0]  half_period;
        logic        inf;
    } state_t;

    localparam state_t STATE_RESET = '{
        phase: PH_IDLE, timer: 12'd0, blink: 4'd0, led: 1'b0, round: 4'd0,
        src: 4'd0, code: 4'd0, half_period: 10'd0, inf: 1'b0
    };

    typedef struct packed {
        logic led_pin;
        logic busy;
        logic skipped;
    } result_t;

    // A zero length lasts one tick
    function automatic logic [11:0] at_least_one(logic [11:0] d);
        return (d == 12'd0) ? 12'd1 : d;
    endfunction

    function automatic logic [11:0] half_len(state_t s);
        return at_least_one({2'b00, s.half_period});
    endfunction

    function automatic state_t go_idle(state_t s);
        state_t r;
        r = s;
        r.phase = PH_IDLE;
        r.timer = 12'd0;
        r.blink = 4'd0;
        r.led   = 1'b0;
        return r;
    endfunction

    function automatic state_t go_gap1(state_t s, logic [11:0] gap);
        state_t r;
        r = s;
        r.phase = PH_GAP1;
        r.led   = 1'b0;
        r.timer = at_least_one(gap);
        return r;
    endfunction

    function automatic state_t go_gap2(state_t s, logic [11:0] gap);
        state_t r;
        r = s;
        r.phase = PH_GAP2;
        r.led   = 1'b0;
        r.timer = at_least_one(gap);
        return r;
    endfunction

    // Start the code blinks, or skip straight to the round gap when empty
    function automatic state_t go_code(state_t s, logic [11:0] gap2);
        state_t r;
        r = s;
        if (s.code == 4'd0) begin
            r = go_gap2(s, gap2);
        end else begin
            r.phase = PH_CODE;
            r.blink = 4'd0;
            r.led   = 1'b1;
            r.timer = half_len(s);
        end
        return r;
    endfunction

    // Start a round with the source blinks, or the first gap when empty
    function automatic state_t go_round(state_t s, logic [11:0] gap1);
        state_t r;
        r = s;
        if (s.src == 4'd0) begin
            r = go_gap1(s, gap1);
        end else begin
            r.phase = PH_SRC;
            r.blink = 4'd0;
            r.led   = 1'b1;
            r.timer = half_len(s);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/slbcs_core.sv -----
// Blink sequence state and its one-pass next-state logic.
`timescale 1ns / 1ps
`default_nettype none

module slbcs_core (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              fire,
    input  wire logic [1:0]        op,
    input  wire logic [3:0]        source_count,
    input  wire logic [3:0]        code_count,
    input  wire logic [9:0]        half_period_ms,
    input  wire logic              infinite,
    input  wire slbcs_pkg::cfg_t   cfg,
    output slbcs_pkg::result_t     result
);
    import slbcs_pkg::*;

    state_t     state_reg;
    state_t     state_next;
    logic       skipped;
    logic [3:0] count;
    logic [3:0] blink_inc;
    logic [3:0] round_inc;
    logic [3:0] round_lim;

    // Compute the state after this item
    always_comb begin
        state_next = state_reg;
        skipped    = 1'b0;
        count      = (state_reg.phase == PH_SRC) ? state_reg.src : state_reg.code;
        blink_inc  = state_reg.blink + 4'd1;
        round_inc  = state_reg.round + 4'd1;
        round_lim  = (cfg.round_total == 4'd0) ? 4'd1 : cfg.round_total;
        case (op)
            OP_TICK: begin
                if (state_reg.phase != PH_IDLE) begin
                    if (state_reg.timer > 12'd1) begin
                        state_next.timer = state_reg.timer - 12'd1;
                    end else begin
                        case (state_reg.phase)
                            PH_SRC, PH_CODE: begin
                                if (state_reg.led) begin
                                    state_next.led   = 1'b0;
                                    state_next.timer = half_len(state_reg);
                                end else begin
                                    state_next.blink = blink_inc;
                                    if (blink_inc < count) begin
                                        state_next.led   = 1'b1;
                                        state_next.timer = half_len(state_reg);
                                    end else if (state_reg.phase == PH_SRC) begin
                                        state_next = go_gap1(state_next, cfg.sc_gap);
                                    end else begin
                                        state_next = go_gap2(state_next, cfg.round_gap);
                                    end
                                end
                            end
                            PH_GAP1: begin
                                state_next = go_code(state_reg, cfg.round_gap);
                            end
                            PH_GAP2: begin
                                if (!state_reg.inf) begin
                                    state_next.round = round_inc;
                                    if (round_inc >= round_lim) begin
                                        state_next = go_idle(state_next);
                                    end else begin
                                        state_next = go_round(state_next, cfg.sc_gap);
                                    end
                                end else begin
                                    state_next = go_round(state_reg, cfg.sc_gap);
                                end
                            end
                            default: begin
                                state_next = go_idle(state_reg);
                            end
                        endcase
                    end
                end
            end
            OP_REQUEST: begin
                if (state_reg.phase != PH_IDLE) begin
                    skipped = 1'b1;
                end else begin
                    state_next.src         = source_count;
                    state_next.code        = code_count;
                    state_next.half_period = half_period_ms;
                    state_next.inf         = infinite;
                    state_next.round       = 4'd0;
                    state_next             = go_round(state_next, cfg.sc_gap);
                end
            end
            OP_OFF: begin
                state_next = go_idle(state_reg);
            end
            default: begin
                state_next = state_reg;
            end
        endcase
    end

    // Hold the sequence state; advance once per item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= STATE_RESET;
        end else if (fire) begin
            state_reg <= state_next;
        end
    end

    // Drive the result of this item
    always_comb begin
        result.led_pin = state_next.led ^ cfg.active_low;
        result.busy    = (state_next.phase != PH_IDLE);
        result.skipped = skipped;
    end

`include "status_led_blink_code_sequencer_macros.svh"

    `SLBCS_ASSERT(a_idle_dark, aclk, aresetn, (state_reg.phase == PH_IDLE) |-> (state_reg.timer == 12'd0 && !state_reg.led && state_reg.blink == 4'd0), "idle state with running timer or lit LED")
    `SLBCS_ASSERT(a_hold_no_item, aclk, aresetn, !fire |=> $stable(state_reg), "state changed without an item")
    `SLBCS_ASSERT(a_src_count, aclk, aresetn, (state_reg.phase == PH_SRC) |-> (state_reg.blink < state_reg.src), "source blink count out of range")
    `SLBCS_ASSERT(a_code_count, aclk, aresetn, (state_reg.phase == PH_CODE) |-> (state_reg.blink < state_reg.code), "code blink count out of range")
    `SLBCS_ASSERT(a_held_stable, aclk, aresetn, !(fire && op == OP_REQUEST && state_reg.phase == PH_IDLE) |=> ($stable(state_reg.src) && $stable(state_reg.code) && $stable(state_reg.half_period)), "held request fields changed outside a start")

endmodule

`default_nettype wire

// ----- rtl/status_led_blink_code_sequencer.sv -----
// Status LED blink code sequencer: item and result registers around the sequence core.
//
// Takes one item per clock cycle (tick, start request or force off) and returns one
// result per item: the item is captured in an input register, the sequence core
// computes the next state in a single pass, and the result is held in an output
// register. One more item still enters the input register while a result waits
// for m_ready, so the sustained rate is one item per cycle whenever the result side
// keeps up; the only loop is the core's state update. Configuration writes are always
// taken (cfg_ready stays high) and must only be issued while no item is in flight.
`timescale 1ns / 1ps
`default_nettype none

module status_led_blink_code_sequencer (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output      logic                               s_ready,
    input  wire logic [1:0]                         s_operation,
    input  wire logic [3:0]                         s_source_count,
    input  wire logic [3:0]                         s_code_count,
    input  wire logic [9:0]                         s_half_period_ms,
    input  wire logic                               s_infinite,
    output      logic                               m_valid,
    input  wire logic                               m_ready,
    output      logic                               m_led_pin,
    output      logic                               m_busy_res,
    output      logic                               m_request_skipped,
    input  wire logic                               cfg_valid,
    output      logic                               cfg_ready,
    input  wire logic [slbcs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [slbcs_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import slbcs_pkg::*;

    logic        in_valid_reg;
    logic [1:0]  op_reg;
    logic [3:0]  src_reg;
    logic [3:0]  code_reg;
    logic [9:0]  half_reg;
    logic        inf_reg;
    logic        out_valid_reg;
    result_t     result_reg;
    result_t     result_next;
    cfg_t        cfg_reg;
    logic        advance;

    // Move an item into the result stage when that stage is free or draining
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // Capture the item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg   <= s_operation;
            src_reg  <= s_source_count;
            code_reg <= s_code_count;
            half_reg <= s_half_period_ms;
            inf_reg  <= s_infinite;
        end
    end

    slbcs_core u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .fire           (advance),
        .op             (op_reg),
        .source_count   (src_reg),
        .code_count     (code_reg),
        .half_period_ms (half_reg),
        .infinite       (inf_reg),
        .cfg            (cfg_reg),
        .result         (result_next)
    );

    // Hold the result until it is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_led_pin         = result_reg.led_pin;
    assign m_busy_res        = result_reg.busy;
    assign m_request_skipped = result_reg.skipped;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.active_low  <= 1'b0;
            cfg_reg.sc_gap      <= SC_GAP_RESET;
            cfg_reg.round_gap   <= ROUND_GAP_RESET;
            cfg_reg.round_total <= ROUND_TOTAL_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_ACTIVE_LOW:  cfg_reg.active_low  <= cfg_data[0];
                CFG_SC_GAP:      cfg_reg.sc_gap      <= cfg_data[11:0];
                CFG_ROUND_GAP:   cfg_reg.round_gap   <= cfg_data[11:0];
                CFG_ROUND_TOTAL: cfg_reg.round_total <= cfg_data[3:0];
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- tb/blink_code_checker.sv -----
`timescale 1ns / 1ps
// Checker for the blink code sequencer: tracks the sequence, forecasts each result, compares.

module blink_code_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [3:0]  s_source_count,
    input  logic [3:0]  s_code_count,
    input  logic [9:0]  s_half_period_ms,
    input  logic        s_infinite,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic        m_led_pin,
    input  logic        m_busy_res,
    input  logic        m_request_skipped,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data,
    output int          mismatches,
    output int          results_owed
);
    import slbcs_pkg::*;

    // Register copies
    logic        invert;
    logic [11:0] gap_src_code;
    logic [11:0] gap_round;
    logic [3:0]  rounds_wanted;

    // Sequence state
    phase_t      seq_phase;
    logic [11:0] seg_timer;
    logic [3:0]  blinks_done;
    logic        lit;
    logic [3:0]  rounds_done;
    logic [3:0]  src_blinks;
    logic [3:0]  code_blinks;
    logic [9:0]  half_ms;
    logic        endless;

    result_t     owed_results[$];

    function automatic logic [11:0] nonzero(logic [11:0] d);
        return (d == 12'd0) ? 12'd1 : d;
    endfunction

    function automatic void enter_pause(phase_t which, logic [11:0] len);
        seq_phase = which;
        lit       = 1'b0;
        seg_timer = nonzero(len);
    endfunction

    function automatic void enter_blinks(phase_t which);
        seq_phase   = which;
        blinks_done = 4'd0;
        lit         = 1'b1;
        seg_timer   = nonzero({2'b00, half_ms});
    endfunction

    function automatic void go_dark();
        seq_phase   = PH_IDLE;
        seg_timer   = 12'd0;
        blinks_done = 4'd0;
        lit         = 1'b0;
    endfunction

    // Start a round; an empty source group goes straight to the first pause
    function automatic void open_round();
        if (src_blinks == 4'd0) begin
            enter_pause(PH_GAP1, gap_src_code);
        end else begin
            enter_blinks(PH_SRC);
        end
    endfunction

    function automatic void advance_tick();
        logic [3:0] group;
        if (seq_phase == PH_IDLE) return;
        if (seg_timer > 12'd1) begin
            seg_timer = seg_timer - 12'd1;
            return;
        end
        case (seq_phase)
            PH_SRC, PH_CODE: begin
                group = (seq_phase == PH_SRC) ? src_blinks : code_blinks;
                if (lit) begin
                    lit       = 1'b0;
                    seg_timer = nonzero({2'b00, half_ms});
                end else begin
                    blinks_done = blinks_done + 4'd1;
                    if (blinks_done < group) begin
                        lit       = 1'b1;
                        seg_timer = nonzero({2'b00, half_ms});
                    end else if (seq_phase == PH_SRC) begin
                        enter_pause(PH_GAP1, gap_src_code);
                    end else begin
                        enter_pause(PH_GAP2, gap_round);
                    end
                end
            end
            PH_GAP1: begin
                if (code_blinks == 4'd0) begin
                    enter_pause(PH_GAP2, gap_round);
                end else begin
                    enter_blinks(PH_CODE);
                end
            end
            PH_GAP2: begin
                // Count the round unless endless; a zero total plays one round
                if (!endless) begin
                    rounds_done = rounds_done + 4'd1;
                    if ({8'd0, rounds_done} >= nonzero({8'd0, rounds_wanted})) begin
                        go_dark();
                        return;
                    end
                end
                open_round();
            end
            default: go_dark();
        endcase
    endfunction

    function automatic result_t step_sequencer(logic [1:0] op, logic [3:0] src,
                                               logic [3:0] code, logic [9:0] half,
                                               logic repeat_all);
        result_t r;
        r.skipped = 1'b0;
        case (op)
            OP_TICK: advance_tick();
            OP_REQUEST: begin
                if (seq_phase != PH_IDLE) begin
                    r.skipped = 1'b1;
                end else begin
                    src_blinks  = src;
                    code_blinks = code;
                    half_ms     = half;
                    endless     = repeat_all;
                    rounds_done = 4'd0;
                    open_round();
                end
            end
            OP_OFF: go_dark();
            default: ;
        endcase
        r.led_pin = lit ^ invert;
        r.busy    = (seq_phase != PH_IDLE);
        return r;
    endfunction

    always @(posedge aclk) begin
        result_t want;
        result_t got;
        if (!aresetn) begin
            invert        = 1'b0;
            gap_src_code  = SC_GAP_RESET;
            gap_round     = ROUND_GAP_RESET;
            rounds_wanted = ROUND_TOTAL_RESET;
            go_dark();
            rounds_done   = 4'd0;
            src_blinks    = 4'd0;
            code_blinks   = 4'd0;
            half_ms       = 10'd0;
            endless       = 1'b0;
            owed_results.delete();
        end else begin
            // Track register writes
            if (cfg_valid && cfg_ready) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_ACTIVE_LOW:  invert        = cfg_data[0];
                    CFG_SC_GAP:      gap_src_code  = cfg_data;
                    CFG_ROUND_GAP:   gap_round     = cfg_data;
                    CFG_ROUND_TOTAL: rounds_wanted = cfg_data[3:0];
                    default: ;
                endcase
            end

            // Compare an accepted result against the oldest forecast
            if (m_valid && m_ready) begin
                got.led_pin = m_led_pin;
                got.busy    = m_busy_res;
                got.skipped = m_request_skipped;
                if (owed_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result with none owed: led=%0b busy=%0b skipped=%0b",
                                 $realtime, got.led_pin, got.busy, got.skipped);
                end else begin
                    want = owed_results.pop_front();
                    if (got.led_pin !== want.led_pin || got.busy !== want.busy ||
                        got.skipped !== want.skipped) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: mismatch led %0b/%0b busy %0b/%0b skipped %0b/%0b %s",
                                     $realtime, want.led_pin, got.led_pin, want.busy,
                                     got.busy, want.skipped, got.skipped,
                                     "(expected/actual)");
                    end
                end
            end

            // Forecast the result of an accepted item
            if (s_valid && s_ready)
                owed_results.push_back(step_sequencer(s_operation, s_source_count,
                                                      s_code_count, s_half_period_ms,
                                                      s_infinite));
        end
        results_owed <= owed_results.size();
    end

endmodule

// ----- tb/tb_status_led_blink_code_sequencer.sv -----
`timescale 1ns / 1ps
// Testbench top for the blink code sequencer: clock, reset, stimulus and verdict.

module tb_status_led_blink_code_sequencer;
    import slbcs_pkg::*;

    // Fourth operation code, which the block ignores
    localparam logic [1:0] OP_SPARE = 2'd3;
    localparam int PHASE_COUNT = 8;
    localparam int PHASE_ITEMS = 210;
    localparam int HOLD_CYCLES = 400;

    logic        aclk              = 1'b0;
    logic        aresetn           = 1'b0;
    logic        s_valid           = 1'b0;
    logic        s_ready;
    logic [1:0]  s_operation       = 2'd0;
    logic [3:0]  s_source_count    = 4'd0;
    logic [3:0]  s_code_count      = 4'd0;
    logic [9:0]  s_half_period_ms  = 10'd1;
    logic        s_infinite        = 1'b0;
    logic        m_valid;
    logic        m_ready           = 1'b0;
    logic        m_led_pin;
    logic        m_busy_res;
    logic        m_request_skipped;
    logic        cfg_valid         = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index         = 2'd0;
    logic [11:0] cfg_data          = 12'd0;

    int          mismatches;
    int          results_owed;
    logic        steady            = 1'b0;
    logic        hold_wanted       = 1'b0;
    logic        hold_used         = 1'b0;
    int          hold_left         = 0;

    status_led_blink_code_sequencer dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_operation       (s_operation),
        .s_source_count    (s_source_count),
        .s_code_count      (s_code_count),
        .s_half_period_ms  (s_half_period_ms),
        .s_infinite        (s_infinite),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_led_pin         (m_led_pin),
        .m_busy_res        (m_busy_res),
        .m_request_skipped (m_request_skipped),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    blink_code_checker blink_check (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_operation       (s_operation),
        .s_source_count    (s_source_count),
        .s_code_count      (s_code_count),
        .s_half_period_ms  (s_half_period_ms),
        .s_infinite        (s_infinite),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_led_pin         (m_led_pin),
        .m_busy_res        (m_busy_res),
        .m_request_skipped (m_request_skipped),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .mismatches        (mismatches),
        .results_owed      (results_owed)
    );

    always #10 aclk = ~aclk;

    // Result side: random stalls, one long hold-off on request
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_wanted && !hold_used) begin
            m_ready   <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end else begin
            m_ready <= steady || ($urandom_range(99) >= 31);
        end
    end

    // Offer one item after a random gap and hold it until taken
    task automatic feed_item(logic [1:0] op, logic [3:0] src, logic [3:0] code,
                             logic [9:0] half, logic repeat_all);
        while (!steady && $urandom_range(99) < 31) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_operation      <= op;
        s_source_count   <= src;
        s_code_count     <= code;
        s_half_period_ms <= half;
        s_infinite       <= repeat_all;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [11:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // Drop valid and wait until every owed result has come back
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (results_owed != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    initial begin
        #4000000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        logic [1:0]  op;
        logic [3:0]  src;
        logic [3:0]  code;
        logic [9:0]  half;
        logic        repeat_all;
        logic        al;
        logic [11:0] scg;
        logic [11:0] rgg;
        logic [3:0]  rt;
        logic [7:0]  junk;
        int          sent;
        int          pick;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Idle behavior, longest request, dropped request, zero lengths at reset values
        feed_item(OP_TICK, 4'd0, 4'd0, 10'd1, 1'b0);
        feed_item(OP_OFF, 4'd0, 4'd0, 10'd1, 1'b0);
        feed_item(OP_SPARE, 4'hF, 4'hF, 10'h3FF, 1'b1);
        feed_item(OP_REQUEST, 4'hF, 4'hF, 10'h3FF, 1'b1);
        feed_item(OP_REQUEST, 4'd5, 4'd6, 10'd1, 1'b0);
        feed_item(OP_TICK, 4'd0, 4'd0, 10'd1, 1'b0);
        feed_item(OP_TICK, 4'd0, 4'd0, 10'd1, 1'b0);
        feed_item(OP_OFF, 4'd0, 4'd0, 10'd1, 1'b0);
        feed_item(OP_REQUEST, 4'd0, 4'd0, 10'd0, 1'b0);
        feed_item(OP_TICK, 4'd0, 4'd0, 10'd1, 1'b0);
        feed_item(OP_OFF, 4'd0, 4'd0, 10'd1, 1'b0);

        // Largest pauses, inverted pin, total masked down to zero
        settle();
        write_reg(CFG_ACTIVE_LOW, 12'hFFF);
        write_reg(CFG_SC_GAP, 12'hFFF);
        write_reg(CFG_ROUND_GAP, 12'hFFF);
        write_reg(CFG_ROUND_TOTAL, 12'hFF0);
        cfg_valid <= 1'b0;
        feed_item(OP_REQUEST, 4'd0, 4'd0, 10'd0, 1'b0);
        feed_item(OP_TICK, 4'd0, 4'd0, 10'd1, 1'b0);
        feed_item(OP_OFF, 4'd0, 4'd0, 10'd1, 1'b0);

        // Zero pauses and zero total: one short round runs to its end
        settle();
        write_reg(CFG_ACTIVE_LOW, 12'd0);
        write_reg(CFG_SC_GAP, 12'd0);
        write_reg(CFG_ROUND_GAP, 12'd0);
        write_reg(CFG_ROUND_TOTAL, 12'd0);
        cfg_valid <= 1'b0;
        feed_item(OP_REQUEST, 4'd0, 4'd0, 10'd0, 1'b0);
        feed_item(OP_TICK, 4'd0, 4'd0, 10'd1, 1'b0);
        feed_item(OP_TICK, 4'd0, 4'd0, 10'd1, 1'b0);
        feed_item(OP_REQUEST, 4'd1, 4'd1, 10'd0, 1'b0);
        repeat (6) feed_item(OP_TICK, 4'd0, 4'd0, 10'd1, 1'b0);

        // Random phases, each under its own register setting
        for (int p = 0; p < PHASE_COUNT; p++) begin
            settle();
            case (p)
                0: begin al = 1'b1; scg = 12'd0; rgg = 12'd0; rt = 4'd1;  end
                1: begin al = 1'b0; scg = 12'd3; rgg = 12'd5; rt = 4'd3;  end
                2: begin al = 1'b1; scg = 12'd1; rgg = 12'd2; rt = 4'd15; end
                3: begin al = 1'b0; scg = 12'd2; rgg = 12'd0; rt = 4'd0;  end
                default: begin
                    al  = 1'($urandom_range(1));
                    scg = 12'($urandom_range(6));
                    rgg = 12'($urandom_range(6));
                    rt  = 4'($urandom_range(15, 1));
                end
            endcase
            junk = 8'($urandom_range(255));
            write_reg(CFG_ACTIVE_LOW, {junk[7:0], 3'd0, al});
            write_reg(CFG_SC_GAP, scg);
            write_reg(CFG_ROUND_GAP, rgg);
            write_reg(CFG_ROUND_TOTAL, {junk, rt});
            cfg_valid <= 1'b0;
            steady <= (p == 2);
            if (p == 4) hold_wanted <= 1'b1;

            sent = 0;
            while (sent < PHASE_ITEMS) begin
                pick       = $urandom_range(99);
                src        = 4'($urandom_range(15));
                code       = 4'($urandom_range(15));
                half       = 10'($urandom_range(1023));
                repeat_all = 1'($urandom_range(1));
                if (pick < 2) begin
                    op = OP_SPARE;
                end else if (pick < 4) begin
                    op = OP_OFF;
                end else if (pick < 12) begin
                    // Mostly short groups and blinks so sequences run to their end
                    op = OP_REQUEST;
                    if ($urandom_range(9) != 0) src = 4'($urandom_range(3));
                    if ($urandom_range(9) != 0) code = 4'($urandom_range(3));
                    pick = $urandom_range(99);
                    if (pick < 85) half = 10'($urandom_range(3));
                    else if (pick < 95) half = 10'($urandom_range(20, 4));
                    repeat_all = ($urandom_range(99) < 20);
                end else begin
                    op = OP_TICK;
                end
                feed_item(op, src, code, half, repeat_all);
                if (op != OP_SPARE) sent++;
            end
        end

        steady <= 1'b0;
        settle();
        if (mismatches == 0 && results_owed == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
